// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk_i, off while rst_ni is low
`define TFN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tfn check failed");

// implication form
`define TFN_ASSERT_IMP(lbl, ante, cons) `TFN_ASSERT(lbl, (ante) |-> (cons))

`endif

// ===== hw/rtl/tfn_pkg.sv =====
package tfn_pkg;

  localparam int VertexSlotsDef = 1024;
  localparam int IdxW   = 10;
  localparam int CoordW = 16;
  localparam int VtxW   = 3 * CoordW;
  localparam int EdgeW  = CoordW + 1;
  localparam int ProdW  = 2 * EdgeW;
  localparam int CrossW = ProdW + 1;
  localparam int MagW   = ProdW;
  localparam int PosW   = 6;
  localparam int NormW  = 31;
  localparam int SqW    = 2 * NormW;
  localparam int SumW   = 64;
  localparam int RootW  = 32;
  localparam int RemW   = RootW + 4;
  localparam int FracW  = 14;
  localparam int QW     = FracW + 1;
  localparam int NumW   = NormW + FracW + 1;
  localparam int OutW   = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                     op;
    logic [IdxW-1:0]          index_a;
    logic [IdxW-1:0]          index_b;
    logic [IdxW-1:0]          index_c;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
  } req_t;

  typedef struct packed {
    logic signed [EdgeW-1:0] ea_x;
    logic signed [EdgeW-1:0] ea_y;
    logic signed [EdgeW-1:0] ea_z;
    logic signed [EdgeW-1:0] eb_x;
    logic signed [EdgeW-1:0] eb_y;
    logic signed [EdgeW-1:0] eb_z;
  } edges_t;

  typedef struct packed {
    logic [MagW-1:0] m_x;
    logic [MagW-1:0] m_y;
    logic [MagW-1:0] m_z;
    logic            s_x;
    logic            s_y;
    logic            s_z;
  } mag_t;

  typedef struct packed {
    logic [NormW-1:0] n_x;
    logic [NormW-1:0] n_y;
    logic [NormW-1:0] n_z;
    logic             s_x;
    logic             s_y;
    logic             s_z;
    logic             deg;
  } lanes_t;

  typedef struct packed {
    logic [SumW-1:0] s;
    lanes_t          lanes;
  } sum_t;

  typedef struct packed {
    logic [RootW-1:0] len;
    lanes_t           lanes;
  } root_t;

  typedef struct packed {
    logic signed [OutW-1:0] normal_x;
    logic signed [OutW-1:0] normal_y;
    logic signed [OutW-1:0] normal_z;
    logic                   degenerate;
  } res_t;

endpackage

// ===== hw/rtl/tfn_in_if.sv =====
interface tfn_in_if import tfn_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [IdxW-1:0]          index_a;
  logic [IdxW-1:0]          index_b;
  logic [IdxW-1:0]          index_c;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;
  logic signed [CoordW-1:0] coord_z;

  modport source (output valid, op, index_a, index_b, index_c, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, op, index_a, index_b, index_c, coord_x, coord_y, coord_z,
                output ready);
endinterface

// ===== hw/rtl/tfn_out_if.sv =====
interface tfn_out_if import tfn_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic signed [OutW-1:0] normal_x;
  logic signed [OutW-1:0] normal_y;
  logic signed [OutW-1:0] normal_z;
  logic                   degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== hw/rtl/triangle_face_normal_top.sv =====
// a normal request passes through registered stages in turn:
//   fetch, cross product, normalize, square root and divide
// throughput: one request per cycle unless out_o stalls; root and divider are fully pipelined
// a vertex write gives no result and is seen by the next request
// reset clears the pipeline valid bits only; vertex store contents are undefined until written
`include "assert_macros.svh"

module triangle_face_normal_top import tfn_pkg::*; #(
  parameter int VERTEX_SLOTS = VertexSlotsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tfn_in_if.sink    in_i,
  tfn_out_if.source out_o
);

  req_t   req;
  edges_t edges;
  mag_t   mag;
  sum_t   sum;
  root_t  root;
  res_t   res;
  logic   f_valid, f_ready, c_valid, c_ready, n_valid, n_ready, s_valid, s_ready;

  always_comb begin
    req.op      = in_i.op;
    req.index_a = in_i.index_a;
    req.index_b = in_i.index_b;
    req.index_c = in_i.index_c;
    req.coord_x = in_i.coord_x;
    req.coord_y = in_i.coord_y;
    req.coord_z = in_i.coord_z;
  end

  tfn_fetch #(.VERTEX_SLOTS(VERTEX_SLOTS)) u_fetch (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid), .in_ready_o (in_i.ready), .in_req_i (req),
    .out_valid_o (f_valid), .out_ready_i (f_ready), .out_edges_o (edges)
  );

  tfn_cross u_cross (
    .clk_i, .rst_ni,
    .in_valid_i (f_valid), .in_ready_o (f_ready), .in_edges_i (edges),
    .out_valid_o (c_valid), .out_ready_i (c_ready), .out_mag_o (mag)
  );

  tfn_norm u_norm (
    .clk_i, .rst_ni,
    .in_valid_i (c_valid), .in_ready_o (c_ready), .in_mag_i (mag),
    .out_valid_o (n_valid), .out_ready_i (n_ready), .out_sum_o (sum)
  );

  tfn_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .in_valid_i (n_valid), .in_ready_o (n_ready), .in_sum_i (sum),
    .out_valid_o (s_valid), .out_ready_i (s_ready), .out_root_o (root)
  );

  tfn_div u_div (
    .clk_i, .rst_ni,
    .in_valid_i (s_valid), .in_ready_o (s_ready), .in_root_i (root),
    .out_valid_o (out_o.valid), .out_ready_i (out_o.ready), .out_res_o (res)
  );

  assign out_o.normal_x   = res.normal_x;
  assign out_o.normal_y   = res.normal_y;
  assign out_o.normal_z   = res.normal_z;
  assign out_o.degenerate = res.degenerate;

  `TFN_ASSERT_IMP(a_deg_zero, out_o.valid && out_o.degenerate, out_o.normal_x == '0 && out_o.normal_y == '0 && out_o.normal_z == '0)
  `TFN_ASSERT_IMP(a_unit_range, out_o.valid, out_o.normal_x >= -16'sd16384 && out_o.normal_x <= 16'sd16384 && out_o.normal_y >= -16'sd16384 && out_o.normal_y <= 16'sd16384 && out_o.normal_z >= -16'sd16384 && out_o.normal_z <= 16'sd16384)
  `TFN_ASSERT_IMP(a_nonzero, out_o.valid && !out_o.degenerate, out_o.normal_x != '0 || out_o.normal_y != '0 || out_o.normal_z != '0)

endmodule

// ===== hw/rtl/tfn_fetch.sv =====
module tfn_fetch import tfn_pkg::*; #(
  parameter int VERTEX_SLOTS = VertexSlotsDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  req_t   in_req_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output edges_t out_edges_o
);

  localparam int AddrW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;

  logic [VtxW-1:0] mem_a [VERTEX_SLOTS];
  logic [VtxW-1:0] mem_b [VERTEX_SLOTS];
  logic [VtxW-1:0] mem_c [VERTEX_SLOTS];

  logic [VtxW-1:0] rd_a_q, rd_b_q, rd_c_q;
  logic            ok_a_q, ok_b_q, ok_c_q;
  logic            v0_q, v1_q, en0, en1;
  edges_t          edges_d, edges_q;
  logic [VtxW-1:0] pa, pb, pc;

  function automatic logic [AddrW-1:0] to_addr(logic [IdxW-1:0] idx);
    logic [31:0] e;
    e = 32'(idx);
    return e[AddrW-1:0];
  endfunction

  function automatic logic in_range(logic [IdxW-1:0] idx);
    return 32'(idx) < 32'(VERTEX_SLOTS);
  endfunction

  assign en1        = !v1_q || out_ready_i;
  assign en0        = !v0_q || en1;
  assign in_ready_o = en0;

  // vertex writes, replicated so three corners read in the same cycle
  always_ff @(posedge clk_i) begin
    if (in_valid_i && en0 && in_req_i.op == OP_WRITE && in_range(in_req_i.index_a)) begin
      mem_a[to_addr(in_req_i.index_a)] <= {in_req_i.coord_x, in_req_i.coord_y, in_req_i.coord_z};
      mem_b[to_addr(in_req_i.index_a)] <= {in_req_i.coord_x, in_req_i.coord_y, in_req_i.coord_z};
      mem_c[to_addr(in_req_i.index_a)] <= {in_req_i.coord_x, in_req_i.coord_y, in_req_i.coord_z};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && en0 && in_req_i.op == OP_QUERY) begin
      rd_a_q <= mem_a[to_addr(in_req_i.index_a)];
      rd_b_q <= mem_b[to_addr(in_req_i.index_b)];
      rd_c_q <= mem_c[to_addr(in_req_i.index_c)];
      ok_a_q <= in_range(in_req_i.index_a);
      ok_b_q <= in_range(in_req_i.index_b);
      ok_c_q <= in_range(in_req_i.index_c);
    end
  end

  assign pa = ok_a_q ? rd_a_q : '0;
  assign pb = ok_b_q ? rd_b_q : '0;
  assign pc = ok_c_q ? rd_c_q : '0;

  always_comb begin
    edges_d.ea_x = EdgeW'($signed(pa[47:32])) - EdgeW'($signed(pb[47:32]));
    edges_d.ea_y = EdgeW'($signed(pa[31:16])) - EdgeW'($signed(pb[31:16]));
    edges_d.ea_z = EdgeW'($signed(pa[15:0]))  - EdgeW'($signed(pb[15:0]));
    edges_d.eb_x = EdgeW'($signed(pa[47:32])) - EdgeW'($signed(pc[47:32]));
    edges_d.eb_y = EdgeW'($signed(pa[31:16])) - EdgeW'($signed(pc[31:16]));
    edges_d.eb_z = EdgeW'($signed(pa[15:0]))  - EdgeW'($signed(pc[15:0]));
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      edges_q <= edges_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) begin
        v0_q <= in_valid_i && in_req_i.op == OP_QUERY;
      end
      if (en1) begin
        v1_q <= v0_q;
      end
    end
  end

  assign out_valid_o = v1_q;
  assign out_edges_o = edges_q;

endmodule

// ===== hw/rtl/tfn_cross.sv =====
module tfn_cross import tfn_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  edges_t in_edges_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output mag_t   out_mag_o
);

  typedef struct packed {
    logic signed [ProdW-1:0] p0;
    logic signed [ProdW-1:0] p1;
    logic signed [ProdW-1:0] p2;
    logic signed [ProdW-1:0] p3;
    logic signed [ProdW-1:0] p4;
    logic signed [ProdW-1:0] p5;
  } prod_t;

  prod_t                    prod_q;
  mag_t                     mag_d, mag_q;
  logic signed [CrossW-1:0] r_x, r_y, r_z;
  logic                     v0_q, v1_q, en0, en1;

  assign en1        = !v1_q || out_ready_i;
  assign en0        = !v0_q || en1;
  assign in_ready_o = en0;

  always_ff @(posedge clk_i) begin
    if (en0) begin
      prod_q.p0 <= ProdW'(in_edges_i.ea_y) * ProdW'(in_edges_i.eb_z);
      prod_q.p1 <= ProdW'(in_edges_i.eb_y) * ProdW'(in_edges_i.ea_z);
      prod_q.p2 <= ProdW'(in_edges_i.eb_x) * ProdW'(in_edges_i.ea_z);
      prod_q.p3 <= ProdW'(in_edges_i.ea_x) * ProdW'(in_edges_i.eb_z);
      prod_q.p4 <= ProdW'(in_edges_i.ea_x) * ProdW'(in_edges_i.eb_y);
      prod_q.p5 <= ProdW'(in_edges_i.eb_x) * ProdW'(in_edges_i.ea_y);
    end
  end

  assign r_x = CrossW'(prod_q.p0) - CrossW'(prod_q.p1);
  assign r_y = CrossW'(prod_q.p2) - CrossW'(prod_q.p3);
  assign r_z = CrossW'(prod_q.p4) - CrossW'(prod_q.p5);

  always_comb begin
    mag_d.s_x = r_x[CrossW-1];
    mag_d.s_y = r_y[CrossW-1];
    mag_d.s_z = r_z[CrossW-1];
    mag_d.m_x = MagW'(r_x[CrossW-1] ? -r_x : r_x);
    mag_d.m_y = MagW'(r_y[CrossW-1] ? -r_y : r_y);
    mag_d.m_z = MagW'(r_z[CrossW-1] ? -r_z : r_z);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mag_q <= mag_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0) begin
        v0_q <= in_valid_i;
      end
      if (en1) begin
        v1_q <= v0_q;
      end
    end
  end

  assign out_valid_o = v1_q;
  assign out_mag_o   = mag_q;

endmodule

// ===== hw/rtl/tfn_norm.sv =====
module tfn_norm import tfn_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  mag_t in_mag_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output sum_t out_sum_o
);

  localparam int WideW = MagW + NormW - 1;

  mag_t             mag_q;
  logic [PosW-1:0]  pos_d, pos_q;
  logic             deg_q;
  lanes_t           lanes_d, lanes_q, lanes2_q;
  logic [SqW-1:0]   sq_x_q, sq_y_q, sq_z_q;
  sum_t             sum_q;
  logic [MagW-1:0]  orw;
  logic [WideW-1:0] t_x, t_y, t_z;
  logic [3:0]       v_q;
  logic [4:0]       en;

  assign en[4] = out_ready_i;
  for (genvar g = 0; g < 4; g++) begin : g_en
    assign en[g] = !v_q[g] || en[g+1];
  end
  assign in_ready_o = en[0];

  // leading one of the largest magnitude
  assign orw = in_mag_i.m_x | in_mag_i.m_y | in_mag_i.m_z;
  always_comb begin
    pos_d = '0;
    for (int i = 0; i < MagW; i++) begin
      if (orw[i]) begin
        pos_d = PosW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mag_q <= in_mag_i;
      pos_q <= pos_d;
      deg_q <= orw == '0;
    end
  end

  // common shift puts the leading one at bit NormW-1
  assign t_x = {mag_q.m_x, (NormW-1)'(0)} >> pos_q;
  assign t_y = {mag_q.m_y, (NormW-1)'(0)} >> pos_q;
  assign t_z = {mag_q.m_z, (NormW-1)'(0)} >> pos_q;

  always_comb begin
    lanes_d.n_x = t_x[NormW-1:0];
    lanes_d.n_y = t_y[NormW-1:0];
    lanes_d.n_z = t_z[NormW-1:0];
    lanes_d.s_x = mag_q.s_x;
    lanes_d.s_y = mag_q.s_y;
    lanes_d.s_z = mag_q.s_z;
    lanes_d.deg = deg_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      lanes_q <= lanes_d;
    end
    if (en[2]) begin
      sq_x_q   <= SqW'(lanes_q.n_x) * SqW'(lanes_q.n_x);
      sq_y_q   <= SqW'(lanes_q.n_y) * SqW'(lanes_q.n_y);
      sq_z_q   <= SqW'(lanes_q.n_z) * SqW'(lanes_q.n_z);
      lanes2_q <= lanes_q;
    end
    if (en[3]) begin
      sum_q.s     <= SumW'(sq_x_q) + SumW'(sq_y_q) + SumW'(sq_z_q);
      sum_q.lanes <= lanes2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  assign out_valid_o = v_q[3];
  assign out_sum_o   = sum_q;

endmodule

// ===== hw/rtl/tfn_sqrt.sv =====
module tfn_sqrt import tfn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  sum_t  in_sum_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output root_t out_root_o
);

  localparam int Steps = RootW;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [SumW-1:0]  s;
    lanes_t           lanes;
  } sq_t;

  sq_t              st_q [Steps];
  logic [Steps-1:0] v_q;
  logic [Steps:0]   en;
  sq_t              init;

  // one result bit per stage, two radicand bits consumed
  function automatic sq_t sq_step(sq_t c);
    logic [RemW-1:0] remx;
    logic [RemW-1:0] trial;
    sq_t             n;
    remx  = {c.rem[RemW-3:0], c.s[SumW-1:SumW-2]};
    trial = {2'b00, c.root, 2'b01};
    n     = c;
    n.s   = {c.s[SumW-3:0], 2'b00};
    if (remx >= trial) begin
      n.rem  = remx - trial;
      n.root = {c.root[RootW-2:0], 1'b1};
    end else begin
      n.rem  = remx;
      n.root = {c.root[RootW-2:0], 1'b0};
    end
    return n;
  endfunction

  always_comb begin
    init.rem   = '0;
    init.root  = '0;
    init.s     = in_sum_i.s;
    init.lanes = in_sum_i.lanes;
  end

  assign en[Steps]  = out_ready_i;
  assign in_ready_o = en[0];

  for (genvar g = 0; g < Steps; g++) begin : g_stage
    sq_t  cur;
    logic vin;
    assign en[g] = !v_q[g] || en[g+1];
    if (g == 0) begin : g_first
      assign cur = init;
      assign vin = in_valid_i;
    end else begin : g_next
      assign cur = st_q[g-1];
      assign vin = v_q[g-1];
    end

    always_ff @(posedge clk_i) begin
      if (en[g]) begin
        st_q[g] <= sq_step(cur);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en[g]) begin
        v_q[g] <= vin;
      end
    end
  end

  assign out_valid_o      = v_q[Steps-1];
  assign out_root_o.len   = st_q[Steps-1].root;
  assign out_root_o.lanes = st_q[Steps-1].lanes;

endmodule

// ===== hw/rtl/tfn_div.sv =====
module tfn_div import tfn_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  root_t in_root_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_res_o
);

  localparam int Stages = QW + 2;

  typedef struct packed {
    logic [RootW-1:0] rem;
    logic [QW-1:0]    low;
    logic [QW-1:0]    q;
  } ln_t;

  typedef struct packed {
    ln_t              x;
    ln_t              y;
    ln_t              z;
    logic [RootW-1:0] len;
    logic             s_x;
    logic             s_y;
    logic             s_z;
    logic             deg;
  } dv_t;

  dv_t               prep_q;
  dv_t               st_q [QW];
  res_t              res_q;
  logic [Stages-1:0] v_q;
  logic [Stages:0]   en;

  function automatic ln_t ln_prep(logic [NormW-1:0] n, logic [RootW-1:0] len);
    logic [NumW-1:0] num;
    ln_t             r;
    num   = NumW'({n, FracW'(0)}) + NumW'(len >> 1);
    r.rem = RootW'(num[NumW-1:QW]);
    r.low = num[QW-1:0];
    r.q   = '0;
    return r;
  endfunction

  function automatic ln_t ln_step(ln_t c, logic [RootW-1:0] len);
    logic [RootW:0] rx;
    ln_t            n;
    rx    = {c.rem, c.low[QW-1]};
    n     = c;
    n.low = {c.low[QW-2:0], 1'b0};
    if (rx >= {1'b0, len}) begin
      n.rem = RootW'(rx - {1'b0, len});
      n.q   = {c.q[QW-2:0], 1'b1};
    end else begin
      n.rem = rx[RootW-1:0];
      n.q   = {c.q[QW-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic dv_t dv_step(dv_t c);
    dv_t n;
    n   = c;
    n.x = ln_step(c.x, c.len);
    n.y = ln_step(c.y, c.len);
    n.z = ln_step(c.z, c.len);
    return n;
  endfunction

  function automatic logic signed [OutW-1:0] apply_sign(logic [QW-1:0] q, logic s, logic deg);
    logic [OutW-1:0] mag;
    mag = OutW'(q);
    if (deg) begin
      return '0;
    end
    return s ? -mag : mag;
  endfunction

  assign en[Stages] = out_ready_i;
  for (genvar g = 0; g < Stages; g++) begin : g_en
    assign en[g] = !v_q[g] || en[g+1];
  end
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      prep_q.x   <= ln_prep(in_root_i.lanes.n_x, in_root_i.len);
      prep_q.y   <= ln_prep(in_root_i.lanes.n_y, in_root_i.len);
      prep_q.z   <= ln_prep(in_root_i.lanes.n_z, in_root_i.len);
      prep_q.len <= in_root_i.len;
      prep_q.s_x <= in_root_i.lanes.s_x;
      prep_q.s_y <= in_root_i.lanes.s_y;
      prep_q.s_z <= in_root_i.lanes.s_z;
      prep_q.deg <= in_root_i.lanes.deg;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_step
    dv_t cur;
    if (g == 0) begin : g_first
      assign cur = prep_q;
    end else begin : g_next
      assign cur = st_q[g-1];
    end
    always_ff @(posedge clk_i) begin
      if (en[g+1]) begin
        st_q[g] <= dv_step(cur);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[Stages-1]) begin
      res_q.normal_x   <= apply_sign(st_q[QW-1].x.q, st_q[QW-1].s_x, st_q[QW-1].deg);
      res_q.normal_y   <= apply_sign(st_q[QW-1].y.q, st_q[QW-1].s_y, st_q[QW-1].deg);
      res_q.normal_z   <= apply_sign(st_q[QW-1].z.q, st_q[QW-1].s_z, st_q[QW-1].deg);
      res_q.degenerate <= st_q[QW-1].deg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < Stages; i++) begin
        if (en[i]) begin
          v_q[i] <= (i == 0) ? in_valid_i : v_q[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign out_valid_o = v_q[Stages-1];
  assign out_res_o   = res_q;

endmodule
